[hdl/pdbf_pkg.sv]
`default_nettype none
package pdbf_pkg;

  localparam int unsigned CfgDataW = 64;
  localparam int unsigned CfgAddrW = 6;

  // Frame layout
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [3:0]  MIN_IHL        = 4'd5;
  localparam logic [7:0]  POS_ETYPE_HI   = 8'd12;
  localparam logic [7:0]  POS_ETYPE_LO   = 8'd13;
  localparam logic [7:0]  POS_IHL        = 8'd14;
  localparam logic [7:0]  POS_PROTO      = 8'd23;
  localparam logic [7:0]  ETH_HDR_BYTES  = 8'd14;
  localparam logic [7:0]  UDP_HDR_BYTES  = 8'd6;
  localparam logic [7:0]  UDP_LAST_OFS   = 8'd5;
  localparam logic [7:0]  POS_MAX        = 8'd255;

  // UDP header byte offsets
  localparam logic [2:0] UDP_SRC_HI = 3'd0;
  localparam logic [2:0] UDP_SRC_LO = 3'd1;
  localparam logic [2:0] UDP_DST_HI = 3'd2;
  localparam logic [2:0] UDP_DST_LO = 3'd3;
  localparam logic [2:0] UDP_LEN_HI = 3'd4;

  // Register reset values
  localparam logic [15:0] RST_PORT_NUMBER = 16'd8805;
  localparam logic [15:0] RST_UDP_LENGTH  = 16'd24;
  localparam logic [7:0]  RST_MSG_TYPE    = 8'd54;
  localparam logic [7:0]  RST_MSG_OFFSET  = 8'd43;
  localparam logic [63:0] RST_WINDOW_NS   = 64'd1000000000;

  typedef enum logic [2:0] {
    REG_PORT_NUMBER = 3'd0,
    REG_UDP_LENGTH  = 3'd1,
    REG_MSG_TYPE    = 3'd2,
    REG_MSG_OFFSET  = 3'd3,
    REG_WINDOW_NS   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [15:0] port_number;
    logic [15:0] udp_length_match;
    logic [7:0]  message_type_match;
    logic [7:0]  message_offset;
    logic [63:0] window_ns;
  } cfg_t;

  // One processed item handed from the parser to the verdict stage
  typedef struct packed {
    logic        eof;
    logic        qualify;
    logic [63:0] time_ns;
  } step_t;

endpackage
`default_nettype wire

[hdl/pdbf_regs.sv]
`default_nettype none
module pdbf_regs
  import pdbf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[CfgAddrW-1:3]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.port_number        <= RST_PORT_NUMBER;
      cfg_q.udp_length_match   <= RST_UDP_LENGTH;
      cfg_q.message_type_match <= RST_MSG_TYPE;
      cfg_q.message_offset     <= RST_MSG_OFFSET;
      cfg_q.window_ns          <= RST_WINDOW_NS;
    end else if (wr_en) begin
      case (idx)
        REG_PORT_NUMBER: cfg_q.port_number        <= pwdata[15:0];
        REG_UDP_LENGTH:  cfg_q.udp_length_match   <= pwdata[15:0];
        REG_MSG_TYPE:    cfg_q.message_type_match <= pwdata[7:0];
        REG_MSG_OFFSET:  cfg_q.message_offset     <= pwdata[7:0];
        REG_WINDOW_NS:   cfg_q.window_ns          <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_PORT_NUMBER: prdata = {48'd0, cfg_q.port_number};
      REG_UDP_LENGTH:  prdata = {48'd0, cfg_q.udp_length_match};
      REG_MSG_TYPE:    prdata = {56'd0, cfg_q.message_type_match};
      REG_MSG_OFFSET:  prdata = {56'd0, cfg_q.message_offset};
      REG_WINDOW_NS:   prdata = cfg_q.window_ns;
      default:         prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule
`default_nettype wire

[hdl/pdbf_parse.sv]
`default_nettype none
module pdbf_parse
  import pdbf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  cfg_t             cfg_i,
  input  wire logic        step_i,
  input  wire logic [7:0]  byte_i,
  input  wire logic        eof_i,
  output logic             qualify_o
);

  logic [7:0]  pos_q, pos_d;
  logic        past_end_q, past_end_d;
  logic [15:0] etype_q, etype_d;
  logic [7:0]  proto_q, proto_d;
  logic [3:0]  hw_q, hw_d;
  logic [15:0] src_q, src_d;
  logic [15:0] dst_q, dst_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  msg_q, msg_d;
  logic [7:0]  udp_start;
  logic [7:0]  udp_ofs;
  logic        in_udp;
  logic        long_enough;

  // UDP header follows the IP header; IHL taken from this byte if it is byte 14
  assign udp_start = ETH_HDR_BYTES + {2'b00, hw_d, 2'b00};
  assign udp_ofs   = pos_q - udp_start;
  assign in_udp    = (pos_q >= udp_start) && (pos_q < udp_start + UDP_HDR_BYTES);

  always_comb begin
    etype_d = etype_q;
    proto_d = proto_q;
    hw_d    = hw_q;
    src_d   = src_q;
    dst_d   = dst_q;
    len_d   = len_q;
    msg_d   = msg_q;
    if (!past_end_q) begin
      if (pos_q == POS_ETYPE_HI) etype_d[15:8] = byte_i;
      if (pos_q == POS_ETYPE_LO) etype_d[7:0]  = byte_i;
      if (pos_q == POS_IHL)      hw_d          = byte_i[3:0];
      if (pos_q == POS_PROTO)    proto_d       = byte_i;
      if (pos_q == cfg_i.message_offset) msg_d = byte_i;
    end
    if (!past_end_q && in_udp) begin
      case (udp_ofs[2:0])
        UDP_SRC_HI: src_d[15:8] = byte_i;
        UDP_SRC_LO: src_d[7:0]  = byte_i;
        UDP_DST_HI: dst_d[15:8] = byte_i;
        UDP_DST_LO: dst_d[7:0]  = byte_i;
        UDP_LEN_HI: len_d[15:8] = byte_i;
        default:    len_d[7:0]  = byte_i;
      endcase
    end
  end

  always_comb begin
    pos_d      = pos_q;
    past_end_d = past_end_q;
    if (pos_q == POS_MAX) past_end_d = 1'b1;
    else                  pos_d      = pos_q + 8'd1;
  end

  // Every needed byte must have been seen, unless the frame ran past byte 255
  assign long_enough = past_end_q ||
                       ((pos_q >= POS_PROTO) && (pos_q >= udp_start + UDP_LAST_OFS) &&
                        (pos_q >= cfg_i.message_offset));

  assign qualify_o = long_enough
                   && (etype_d == ETHERTYPE_IPV4)
                   && (proto_d == PROTO_UDP)
                   && (hw_d >= MIN_IHL)
                   && (src_d == cfg_i.port_number)
                   && (dst_d == cfg_i.port_number)
                   && (len_d == cfg_i.udp_length_match)
                   && (msg_d == cfg_i.message_type_match);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      past_end_q <= 1'b0;
      etype_q    <= '0;
      proto_q    <= '0;
      hw_q       <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      len_q      <= '0;
      msg_q      <= '0;
    end else if (step_i) begin
      if (eof_i) begin
        pos_q      <= '0;
        past_end_q <= 1'b0;
        etype_q    <= '0;
        proto_q    <= '0;
        hw_q       <= '0;
        src_q      <= '0;
        dst_q      <= '0;
        len_q      <= '0;
        msg_q      <= '0;
      end else begin
        pos_q      <= pos_d;
        past_end_q <= past_end_d;
        etype_q    <= etype_d;
        proto_q    <= proto_d;
        hw_q       <= hw_d;
        src_q      <= src_d;
        dst_q      <= dst_d;
        len_q      <= len_d;
        msg_q      <= msg_d;
      end
    end
  end

endmodule
`default_nettype wire

[hdl/pdbf_verdict.sv]
`default_nettype none
module pdbf_verdict
  import pdbf_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [63:0] window_ns_i,
  input  wire logic        step_i,
  input  step_t            step_data_i,
  input  wire logic        out_ready_i,
  output logic             out_valid_o,
  output logic             keep_o,
  output logic             can_load_o
);

  logic        out_valid_q;
  logic        keep_q, keep_d;
  logic        have_prev_q;
  logic [63:0] prev_stamp_q;
  logic [63:0] delta;
  logic        fire;
  logic        hit;

  assign can_load_o = !out_valid_q || out_ready_i;
  assign fire       = step_i && step_data_i.eof;
  assign hit        = fire && step_data_i.qualify;

  // Mod 2^64 delta, so a wrapped clock gives a large value
  assign delta  = step_data_i.time_ns - prev_stamp_q;
  assign keep_d = step_data_i.qualify && have_prev_q && (delta < window_ns_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      have_prev_q <= 1'b0;
    end else begin
      if (fire)             out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (hit) have_prev_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) keep_q <= keep_d;
    if (hit)  prev_stamp_q <= step_data_i.time_ns;
  end

  assign out_valid_o = out_valid_q;
  assign keep_o      = keep_q;

endmodule
`default_nettype wire

[hdl/pfcp_deletion_burst_filter_unit.sv]
`default_nettype none
// Channel   | Dir | Handshake                  | Payload
// s_axis    | in  | s_axis_tvalid/tready       | tdata[7:0] frame_byte, [71:8] time_ns;
//           |     |                            | tlast end_of_frame
// m_axis    | out | m_axis_tvalid/tready       | tdata[0] keep, [7:1] zero
// apb       | in  | psel/penable/pwrite/pready | 64-bit regs at 8*index
//
// One byte per cycle sustained, except that an end-of-frame byte waits while the last verdict is not yet taken.
// Latency is set by the input register and the result register around the
// byte capture, field compare and 64-bit window compare.
// Reset clears the frame position, the stored-match flag and both valid flags.
// A pending verdict holds off input only once the next end-of-frame byte sits in the
// input register; the bytes before it flow.
module pfcp_deletion_burst_filter_unit
  import pdbf_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [71:0]         s_axis_tdata,   // frame_byte, time_ns
  input  wire logic                s_axis_tlast,
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic      [7:0]          m_axis_tdata,   // keep, 7 zero bits
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [CfgAddrW-1:0] paddr,
  input  wire logic [CfgDataW-1:0] pwdata,
  output logic      [CfgDataW-1:0] prdata,
  output logic                     pready
);

  cfg_t        cfg;
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_eof_q;
  logic [63:0] in_time_q;
  logic        advance;
  logic        can_load;
  logic        qualify;
  logic        keep;
  step_t       step_data;

  pdbf_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign advance       = in_valid_q && (!in_eof_q || can_load);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q <= s_axis_tdata[7:0];
      in_time_q <= s_axis_tdata[71:8];
      in_eof_q  <= s_axis_tlast;
    end
  end

  pdbf_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .eof_i     (in_eof_q),
    .qualify_o (qualify)
  );

  assign step_data.eof     = in_eof_q;
  assign step_data.qualify = qualify;
  assign step_data.time_ns = in_time_q;

  pdbf_verdict u_verdict (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_ns_i (cfg.window_ns),
    .step_i      (advance),
    .step_data_i (step_data),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .keep_o      (keep),
    .can_load_o  (can_load)
  );

  assign m_axis_tdata = {7'd0, keep};

endmodule
`default_nettype wire

[hdl/pdbf_checker.sv]
`default_nettype none
module pdbf_checker
  import pdbf_pkg::*;
(
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       s_axis_tready,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  // A held verdict must stay put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("verdict dropped or changed while stalled");

  // Input only backs up behind an unaccepted verdict
  a_bp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled with no pending verdict");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("padding bits of verdict not zero");

  // No verdict can exist right out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid)
    else $error("verdict valid right after reset");

endmodule

bind pfcp_deletion_burst_filter_unit pdbf_checker u_pdbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

[tb/pfcp_deletion_burst_filter_unit_tb.sv]
`timescale 1ns / 100ps
module pfcp_deletion_burst_filter_unit_tb;
  import pdbf_pkg::*;

  localparam int DrainCycles = 6;
  localparam int MaxFrame    = 320;

  typedef enum int {
    FRAME_GOOD,
    FRAME_SHORT,
    FRAME_BAD_IHL,
    FRAME_CORRUPT,
    FRAME_NOISE,
    FRAME_LONG
  } frame_kind_e;

  // Predicts the keep/drop verdict of each frame and holds the verdicts still owed
  class pfcp_verdict_scoreboard;
    logic [15:0] port_req;
    logic [15:0] udp_len_req;
    logic [7:0]  msg_type_req;
    logic [7:0]  msg_ofs;
    logic [63:0] window;

    logic [7:0]  pos;
    bit          past_end;
    logic [15:0] etype;
    logic [7:0]  proto;
    logic [3:0]  ihl;
    logic [15:0] sport;
    logic [15:0] dport;
    logic [15:0] ulen;
    logic [7:0]  mtype;
    bit          have_prev;
    logic [63:0] prev_stamp;

    bit keep_q[$];
    int errors;

    function new();
      port_req     = RST_PORT_NUMBER;
      udp_len_req  = RST_UDP_LENGTH;
      msg_type_req = RST_MSG_TYPE;
      msg_ofs      = RST_MSG_OFFSET;
      window       = RST_WINDOW_NS;
      clear_frame();
      have_prev  = 1'b0;
      prev_stamp = '0;
      errors     = 0;
    endfunction

    function void clear_frame();
      pos      = '0;
      past_end = 1'b0;
      etype    = '0;
      proto    = '0;
      ihl      = '0;
      sport    = '0;
      dport    = '0;
      ulen     = '0;
      mtype    = '0;
    endfunction

    function void write_reg(reg_idx_e idx, logic [63:0] value);
      case (idx)
        REG_PORT_NUMBER: port_req     = value[15:0];
        REG_UDP_LENGTH:  udp_len_req  = value[15:0];
        REG_MSG_TYPE:    msg_type_req = value[7:0];
        REG_MSG_OFFSET:  msg_ofs      = value[7:0];
        REG_WINDOW_NS:   window       = value;
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b, logic eof, logic [63:0] stamp);
      int unsigned p;
      int unsigned udp;
      bit beyond;
      bit ok;
      bit keep;
      p      = pos;
      beyond = past_end;
      if (!past_end) begin
        if (p == POS_ETYPE_HI) etype[15:8] = b;
        if (p == POS_ETYPE_LO) etype[7:0] = b;
        if (p == POS_IHL) ihl = b[3:0];
        if (p == POS_PROTO) proto = b;
        udp = ETH_HDR_BYTES + 4 * ihl;
        if (p >= udp && p < udp + UDP_HDR_BYTES) begin
          case (p - udp)
            UDP_SRC_HI: sport[15:8] = b;
            UDP_SRC_LO: sport[7:0]  = b;
            UDP_DST_HI: dport[15:8] = b;
            UDP_DST_LO: dport[7:0]  = b;
            UDP_LEN_HI: ulen[15:8]  = b;
            default:    ulen[7:0]   = b;
          endcase
        end
        if (p == msg_ofs) mtype = b;
      end
      if (pos == POS_MAX) past_end = 1'b1;
      else pos++;
      if (!eof) return;

      udp = ETH_HDR_BYTES + 4 * ihl;
      // a frame counts only if it reached every byte the checks look at
      ok = (beyond || (p >= POS_PROTO && p >= udp + UDP_LAST_OFS && p >= msg_ofs))
           && etype == ETHERTYPE_IPV4 && proto == PROTO_UDP && ihl >= MIN_IHL
           && sport == port_req && dport == port_req && ulen == udp_len_req
           && mtype == msg_type_req;
      keep = 1'b0;
      if (ok) begin
        if (have_prev && (stamp - prev_stamp) < window) keep = 1'b1;
        prev_stamp = stamp;
        have_prev  = 1'b1;
      end
      clear_frame();
      keep_q.push_back(keep);
    endfunction

    function void check_verdict(logic [7:0] data);
      bit want;
      if (keep_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected verdict, expected none, got tdata=%02h", $time, data);
        return;
      end
      want = keep_q.pop_front();
      if (data !== {7'b0, want}) begin
        errors++;
        $display("%0t: verdict mismatch, expected tdata=%02h, got %02h",
                 $time, {7'b0, want}, data);
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [71:0]         s_axis_tdata = '0;   // frame_byte [7:0], time_ns [71:8]
  logic                s_axis_tlast = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;        // keep [0], zero [7:1]
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [CfgAddrW-1:0] paddr = '0;
  logic [CfgDataW-1:0] pwdata = '0;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  pfcp_verdict_scoreboard sb = new();

  int          burst_left = 0;
  int          items_sent = 0;
  logic [63:0] last_stamp = '0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int          rx_cyc = 0;

  pfcp_deletion_burst_filter_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // receiver: picks one of four ready patterns and draws a new one when its run ends
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(20, 150);
    end
    rx_left--;
    rx_cyc++;
    case (rx_mode)
      0: m_axis_tready = 1'b1;
      1: m_axis_tready = $urandom_range(0, 1);
      2: m_axis_tready = ($urandom_range(0, 7) == 0);
      default: m_axis_tready = (rx_cyc % 16) < 4;
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata);
  end

  // called at a falling edge, returns at a falling edge
  task automatic push_byte(input logic [7:0] b, input logic eof, input logic [63:0] stamp);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 3))
        0: gap = 0;
        1: gap = $urandom_range(1, 3);
        2: gap = $urandom_range(4, 12);
        default: gap = $urandom_range(0, 1);
      endcase
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        s_axis_tvalid = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {stamp, b};
    s_axis_tlast  = eof;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b, eof, stamp);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid = 1'b0;
    burst_left    = 0;
    while (sb.keep_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic apb_write(input reg_idx_e idx, input logic [63:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = CfgAddrW'(8 * int'(idx));
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.write_reg(idx, value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic configure(input logic [15:0] port, input logic [15:0] ulen,
                           input logic [7:0] mtype, input logic [7:0] mofs,
                           input logic [63:0] win);
    wait_drained();
    apb_write(REG_PORT_NUMBER, {32'($urandom), 16'($urandom), port});
    apb_write(REG_UDP_LENGTH,  {32'($urandom), 16'($urandom), ulen});
    apb_write(REG_MSG_TYPE,    {32'($urandom), 24'($urandom), mtype});
    apb_write(REG_MSG_OFFSET,  {32'($urandom), 24'($urandom), mofs});
    apb_write(REG_WINDOW_NS,   win);
  endtask

  function automatic logic [63:0] next_stamp();
    logic [63:0] w;
    logic [63:0] r;
    w = sb.window;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: next_stamp = last_stamp + w - 1;
      1: next_stamp = last_stamp + w;
      2: next_stamp = last_stamp + w + 1;
      3: next_stamp = (w == 0) ? last_stamp : last_stamp + r % w;
      4: next_stamp = r;
      5: next_stamp = last_stamp;
      6: next_stamp = last_stamp - $urandom_range(1, 1000);  // clock wrap
      default: next_stamp = last_stamp + $urandom_range(0, 5000);
    endcase
  endfunction

  function automatic frame_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) pick_kind = FRAME_GOOD;
    else if (r < 72) pick_kind = FRAME_SHORT;
    else if (r < 78) pick_kind = FRAME_BAD_IHL;
    else if (r < 88) pick_kind = FRAME_CORRUPT;
    else if (r < 97) pick_kind = FRAME_NOISE;
    else pick_kind = FRAME_LONG;
  endfunction

  task automatic send_frame(input frame_kind_e kind, input logic [63:0] stamp);
    logic [7:0] fb [0:MaxFrame-1];
    int ihl_v;
    int udp;
    int need;
    int len;
    int at;
    for (int i = 0; i < MaxFrame; i++) fb[i] = $urandom;
    ihl_v = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : 5;
    udp   = ETH_HDR_BYTES + 4 * ihl_v;
    need  = udp + UDP_LAST_OFS;
    if (need < POS_PROTO) need = POS_PROTO;
    if (need < sb.msg_ofs) need = sb.msg_ofs;
    need++;
    if (kind != FRAME_NOISE) begin
      fb[POS_ETYPE_HI] = ETHERTYPE_IPV4[15:8];
      fb[POS_ETYPE_LO] = ETHERTYPE_IPV4[7:0];
      fb[POS_IHL]      = {fb[POS_IHL][7:4], 4'(ihl_v)};
      fb[POS_PROTO]    = PROTO_UDP;
      fb[udp]          = sb.port_req[15:8];
      fb[udp + 1]      = sb.port_req[7:0];
      fb[udp + 2]      = sb.port_req[15:8];
      fb[udp + 3]      = sb.port_req[7:0];
      fb[udp + 4]      = sb.udp_len_req[15:8];
      fb[udp + 5]      = sb.udp_len_req[7:0];
      fb[sb.msg_ofs]   = sb.msg_type_req;
    end
    case (kind)
      FRAME_SHORT: len = $urandom_range(1, need - 1);
      FRAME_NOISE: len = $urandom_range(1, 24);
      FRAME_LONG:  len = $urandom_range(256, 300);
      default: begin
        len = need + (($urandom_range(0, 3) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 4));
        if (kind == FRAME_BAD_IHL) begin
          fb[POS_IHL][3:0] = $urandom_range(0, 4);
        end else if (kind == FRAME_CORRUPT) begin
          case ($urandom_range(0, 9))
            0: at = POS_ETYPE_HI;
            1: at = POS_ETYPE_LO;
            2: at = POS_PROTO;
            9: at = sb.msg_ofs;
            default: at = udp + $urandom_range(0, 5);
          endcase
          fb[at][$urandom_range(0, 7)] ^= 1'b1;
        end
      end
    endcase
    for (int i = 0; i < len; i++) begin
      push_byte(fb[i], i == len - 1, (i == len - 1) ? stamp : {$urandom, $urandom});
    end
    last_stamp = stamp;
  endtask

  initial begin
    int budget;
    int min_frames;
    int start_items;
    int frames;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: tiny frames, window edges, wrap, broken headers
    push_byte(8'hFF, 1'b1, 64'h0);
    send_frame(FRAME_GOOD, 64'd100);                     // first match has no previous
    send_frame(FRAME_GOOD, last_stamp + RST_WINDOW_NS - 1);
    send_frame(FRAME_GOOD, last_stamp + RST_WINDOW_NS);  // exactly one window: drop
    send_frame(FRAME_GOOD, last_stamp - 1);              // wraps to a huge delta
    send_frame(FRAME_SHORT, last_stamp);
    send_frame(FRAME_GOOD, last_stamp);
    send_frame(FRAME_BAD_IHL, last_stamp);
    send_frame(FRAME_CORRUPT, last_stamp);
    send_frame(FRAME_GOOD, 64'hFFFF_FFFF_FFFF_FFFF);
    send_frame(FRAME_GOOD, 64'h0);
    send_frame(FRAME_LONG, last_stamp + 1);
    send_frame(FRAME_NOISE, last_stamp);

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: configure(16'h0000, 16'h0000, 8'h00, 8'h00, 64'h0);
        2: configure(16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 64'hFFFF_FFFF_FFFF_FFFF);
        3: configure($urandom, $urandom, $urandom, $urandom_range(0, 90),
                     {$urandom, $urandom});
        4: configure(RST_PORT_NUMBER, RST_UDP_LENGTH, RST_MSG_TYPE, RST_MSG_OFFSET, 64'd2500);
        5: configure($urandom, $urandom, $urandom, $urandom_range(0, 255),
                     $urandom_range(0, 20000));
        default: ;
      endcase
      // message type at the last header offset makes every frame long
      budget      = (ph == 2) ? 0 : 80;
      min_frames  = (ph == 2) ? 1 : 2;
      start_items = items_sent;
      frames      = 0;
      while (items_sent - start_items < budget || frames < min_frames) begin
        send_frame(pick_kind(), next_stamp());
        frames++;
        if ($urandom_range(0, 30) == 0) wait_drained();
      end
    end

    wait_drained();
    if (sb.errors == 0 && sb.keep_q.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
